/* design/ght_pkg.sv */
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants for the generational handle table: request and
// response items, status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

   // table size default
   localparam int SLOTS_DEFAULT = 64;

   // slot-used bits are kept in words of this size
   localparam int WORD_LSB  = 5;
   localparam int WORD_BITS = 1 << WORD_LSB;

   // handle layout
   localparam logic [7:0]  TYPE_TAG  = 8'h43;
   localparam logic [23:0] GEN_MASK  = 24'hffffff;
   localparam logic [23:0] GEN_FIRST = 24'd1;

   // request codes
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_CHECK   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_HANDLE = 2'd1,
      ST_FULL       = 2'd2,
      ST_BAD_ARG    = 2'd3
   } status_type;

   // request item
   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] handle;
      logic [15:0] owner;
   } ght_req_type;

   // response item
   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] new_handle;
   } ght_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       clear_step;
      logic       capture;
      logic       rd_lookup;
      logic       rd_hint;
      logic       hint_inc;
      logic       pick;
      logic       alloc_commit;
      logic       release_commit;
      logic       set_res;
      status_type res_code;
      logic       load_rsp;
   } ght_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic is_alloc;
      logic is_check;
      logic is_release;
      logic owner_zero;
      logic fmt_ok;
      logic hint_full;
      logic word_full;
      logic hit;
   } ght_flag_type;

endpackage

`default_nettype wire

/* design/ght_datapath.sv */
// ----------------------------------------------------------------------------
// ght_datapath
// Slot storage and handle logic: used-bit word memory, generation/owner
// memory, free-word hint, request and result registers, response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_datapath
   import ght_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ght_req_type req_data,
   input  wire ght_cmd_type cmd,
   output ght_flag_type     flag,
   output ght_rsp_type      rsp_data
);

   localparam int NWORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int HW     = $clog2(NWORDS + 1);
   localparam int IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SIW    = WW + WORD_LSB;

   typedef struct packed {
      logic [23:0] gen;
      logic [15:0] owner;
   } entry_type;

   // storage
   logic [WORD_BITS-1:0] used_mem [NWORDS];
   entry_type            ent_mem  [SLOTS];

   // registers
   ght_req_type          req_ff;
   logic [IW-1:0]        clr_ff,  clr_in;
   logic [HW-1:0]        hint_ff, hint_in;
   logic [WORD_BITS-1:0] used_rd_ff;
   entry_type            ent_rd_ff;
   logic [IW-1:0]        slot_ff;
   logic [WORD_LSB-1:0]  bit_ff;
   status_type           status_ff;
   logic [63:0]          handle_ff, handle_in;
   ght_rsp_type          rsp_ff;

   // decode of the held request
   logic [31:0]          low;
   logic [23:0]          hgen;
   logic [SIW-1:0]       idx_ext;
   logic [WW-1:0]        idx_word;
   logic [WORD_LSB-1:0]  idx_bit;
   logic [IW-1:0]        idx_slot;

   assign low      = req_ff.handle[31:0];
   assign hgen     = req_ff.handle[55:32];
   assign idx_ext  = SIW'(low - 32'd1);
   assign idx_word = idx_ext[SIW-1:WORD_LSB];
   assign idx_bit  = idx_ext[WORD_LSB-1:0];
   assign idx_slot = idx_ext[IW-1:0];

   // clearing pass position
   logic [SIW-1:0]       clr_ext;
   logic [WW-1:0]        clr_word;
   logic [WORD_BITS-1:0] pad_mask;

   assign clr_ext  = SIW'(clr_ff);
   assign clr_word = clr_ext[SIW-1:WORD_LSB];

   // bits past the last slot are marked used so they are never handed out
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         pad_mask[b] = (32'({clr_word, WORD_LSB'(b)}) >= 32'(SLOTS));
      end
   end

   // lowest free bit of the word being scanned
   logic [WORD_LSB-1:0] pe_bit;
   always_comb begin
      pe_bit = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!used_rd_ff[b]) pe_bit = WORD_LSB'(b);
      end
   end

   logic [WW-1:0] hint_w;
   logic [IW-1:0] pick_slot;
   assign hint_w    = hint_ff[WW-1:0];
   assign pick_slot = IW'({hint_w, pe_bit});

   // generation advance, wrapping past the top to the first generation
   logic [23:0] next_gen;
   assign next_gen = (ent_rd_ff.gen == GEN_MASK) ? GEN_FIRST : ent_rd_ff.gen + 24'd1;

   // used-word memory port control
   logic                 used_we, used_re;
   logic [WW-1:0]        used_wa, used_ra;
   logic [WORD_BITS-1:0] used_wd;

   always_comb begin
      used_we = (cmd.clear_step && (clr_ext[WORD_LSB-1:0] == '0))
                || cmd.alloc_commit || cmd.release_commit;
      if (cmd.clear_step) begin
         used_wa = clr_word;
         used_wd = pad_mask;
      end else if (cmd.alloc_commit) begin
         used_wa = hint_w;
         used_wd = used_rd_ff | (WORD_BITS'(1) << bit_ff);
      end else begin
         used_wa = idx_word;
         used_wd = used_rd_ff & ~(WORD_BITS'(1) << idx_bit);
      end
      used_re = cmd.rd_hint || cmd.rd_lookup;
      used_ra = cmd.rd_hint ? hint_w : idx_word;
   end

   // entry memory port control
   logic          ent_we, ent_re;
   logic [IW-1:0] ent_wa, ent_ra;
   entry_type     ent_wd;

   always_comb begin
      ent_we = cmd.clear_step || cmd.alloc_commit || cmd.release_commit;
      if (cmd.clear_step) begin
         ent_wa = clr_ff;
         ent_wd = '{gen: GEN_FIRST, owner: 16'd0};
      end else if (cmd.alloc_commit) begin
         ent_wa = slot_ff;
         ent_wd = '{gen: ent_rd_ff.gen, owner: req_ff.owner};
      end else begin
         ent_wa = idx_slot;
         ent_wd = '{gen: next_gen, owner: ent_rd_ff.owner};
      end
      ent_re = cmd.pick || cmd.rd_lookup;
      ent_ra = cmd.pick ? pick_slot : idx_slot;
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (used_we) used_mem[used_wa] <= used_wd;
      if (used_re) used_rd_ff <= used_mem[used_ra];
      if (ent_we) ent_mem[ent_wa] <= ent_wd;
      if (ent_re) ent_rd_ff <= ent_mem[ent_ra];
   end

   // clear counter and free-word hint
   always_comb begin
      clr_in  = cmd.clear_step ? clr_ff + IW'(1) : clr_ff;
      hint_in = hint_ff;
      if (cmd.hint_inc) begin
         hint_in = hint_ff + HW'(1);
      end else if (cmd.release_commit && (HW'(idx_word) < hint_ff)) begin
         hint_in = HW'(idx_word);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         hint_ff <= '0;
      end else begin
         clr_ff  <= clr_in;
         hint_ff <= hint_in;
      end
   end

   // issued handle
   always_comb begin
      handle_in = '0;
      if (cmd.alloc_commit) begin
         handle_in = {TYPE_TAG, ent_rd_ff.gen, 32'(slot_ff) + 32'd1};
      end
   end

   // request, pick and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.pick) begin
         slot_ff <= pick_slot;
         bit_ff  <= pe_bit;
      end
      if (cmd.set_res) begin
         status_ff <= cmd.res_code;
         handle_ff <= handle_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.new_handle <= handle_ff;
      end
   end

   assign rsp_data = rsp_ff;

   // status toward the controller
   always_comb begin
      flag.clear_last = (clr_ff == IW'(SLOTS - 1));
      flag.is_alloc   = (req_ff.req_type == OP_ALLOC);
      flag.is_check   = (req_ff.req_type == OP_CHECK);
      flag.is_release = (req_ff.req_type == OP_RELEASE);
      flag.owner_zero = (req_ff.owner == 16'd0);
      flag.fmt_ok     = (req_ff.handle[63:56] == TYPE_TAG) && (low != 32'd0)
                        && (hgen != 24'd0) && (low <= 32'(SLOTS));
      flag.hint_full  = (hint_ff == HW'(NWORDS));
      flag.word_full  = &used_rd_ff;
      flag.hit        = used_rd_ff[idx_bit] && (ent_rd_ff.gen == hgen)
                        && (ent_rd_ff.owner == req_ff.owner);
   end

endmodule

`default_nettype wire

/* design/ght_ctrl.sv */
// ----------------------------------------------------------------------------
// ght_ctrl
// Sequencer for the handle table: clearing pass after reset, request decode,
// free-slot scan, lookup, commit, and the response handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ctrl
   import ght_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire ght_flag_type flag,
   output ght_cmd_type       cmd
);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_DECODE = 8'b0000_0100,
      S_SEEK   = 8'b0000_1000,
      S_SCAN   = 8'b0001_0000,
      S_ALLOC  = 8'b0010_0000,
      S_MATCH  = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_code = ST_OK;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (flag.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (flag.is_alloc) begin
               if (flag.owner_zero) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ST_BAD_ARG;
                  state_in     = S_DONE;
               end else if (flag.hint_full) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ST_FULL;
                  state_in     = S_DONE;
               end else begin
                  cmd.rd_hint = 1'b1;
                  state_in    = S_SCAN;
               end
            end else if (flag.is_check || flag.is_release) begin
               if (!flag.fmt_ok) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ST_BAD_HANDLE;
                  state_in     = S_DONE;
               end else begin
                  cmd.rd_lookup = 1'b1;
                  state_in      = S_MATCH;
               end
            end else begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_BAD_ARG;
               state_in     = S_DONE;
            end
         end
         S_SEEK: begin
            if (flag.hint_full) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_FULL;
               state_in     = S_DONE;
            end else begin
               cmd.rd_hint = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (flag.word_full) begin
               cmd.hint_inc = 1'b1;
               state_in     = S_SEEK;
            end else begin
               cmd.pick = 1'b1;
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            cmd.alloc_commit = 1'b1;
            cmd.set_res      = 1'b1;
            cmd.res_code     = ST_OK;
            state_in         = S_DONE;
         end
         S_MATCH: begin
            cmd.set_res = 1'b1;
            state_in    = S_DONE;
            if (!flag.hit) begin
               cmd.res_code = ST_BAD_HANDLE;
            end else begin
               cmd.res_code       = ST_OK;
               cmd.release_commit = flag.is_release;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // response valid holds until taken
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* design/generational_handle_table.sv */
// Check and release: an accepted item passes through decode and match, then done loads the
// response register. Allocate: decode, scan and alloc, plus a seek and a scan for each full
// 32-slot word stepped over by the free-slot scan; requests refused at decode go to done.
// One item is in flight at a time; a finished item waits in the response register.
// After reset a clearing pass steps through every slot, writes its generation to 1 and
// marks all slots free; no item is accepted during it.
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map issuing generational 64-bit handles: allocate, check and release,
// built as a sequencer plus a datapath with used-bit and entry memories.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table
   import ght_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ght_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ght_rsp_type      rsp_data
);

   ght_cmd_type  cmd;
   ght_flag_type flag;

   // sequencer
   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flag      (flag),
      .cmd       (cmd)
   );

   // storage and handle logic
   ght_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .flag     (flag),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

/* design/ght_checker.sv */
// ----------------------------------------------------------------------------
// ght_checker
// Port-level checks for the handle table, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_checker
   import ght_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire ght_req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire ght_rsp_type rsp_data
);

   // reset starts the clearing pass: nothing taken, nothing offered
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!req_ready && !rsp_valid))
      else $error("item traffic right after reset");

   // one item at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in work");

   // a waiting request item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_data)))
      else $error("request changed while waiting");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response changed while stalled");

   // an issued handle is well formed and only comes with ok status
   a_handle_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.new_handle != 64'd0)) |->
         ((rsp_data.status == ST_OK) && (rsp_data.new_handle[63:56] == TYPE_TAG)
          && (rsp_data.new_handle[55:32] != 24'd0)
          && (rsp_data.new_handle[31:0] != 32'd0)))
      else $error("malformed issued handle");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
